// ----- sv/m4i_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// m4i_pkg: shared types, constants and operand tables
// Holds the sequencer states, the operation codes of the cofactor programme
// and the element-address table used to walk each 3x3 minor.
// ----------------------------------------------------------------------------
package m4i_pkg;

   localparam int ELEM_WIDTH_DEF = 16;
   localparam int INV_SHIFT      = 24;
   localparam int MAT_DEPTH      = 16;
   localparam logic [3:0] LAST_OP  = 4'd14;
   localparam logic [3:0] LAST_IDX = 4'd15;

   typedef enum logic [2:0] {
      OP_LDA, OP_MSET, OP_MSUB, OP_MMSET, OP_MMSUB, OP_MMADD
   } op_kind_type;

   typedef enum logic [2:0] {
      CS_IDLE, CS_ISSUE, CS_EXEC, CS_ACC, CS_WRITE, CS_DISSUE, CS_DEXEC, CS_DACC
   } cof_state_type;

   typedef enum logic [1:0] {
      DV_IDLE, DV_RUN, DV_FIN
   } div_state_type;

   typedef enum logic [2:0] {
      TS_LOAD, TS_COF, TS_CHECK, TS_RD, TS_DST, TS_DIV
   } top_state_type;

   typedef struct packed {
      logic       we;
      logic [3:0] addr;
   } cof_wr_type;

   // Operation performed at each step of a cofactor programme.
   function automatic op_kind_type op_kind(input logic [3:0] s);
      op_kind_type k;
      case (s)
         4'd1, 4'd6, 4'd11: k = OP_MSET;
         4'd3, 4'd8, 4'd13: k = OP_MSUB;
         4'd4:              k = OP_MMSET;
         4'd9:              k = OP_MMSUB;
         4'd14:             k = OP_MMADD;
         default:           k = OP_LDA;
      endcase
      return k;
   endfunction

   // Store address of the minor element used at step s of cofactor (r, c).
   function automatic logic [3:0] op_addr(input logic [1:0] r, input logic [1:0] c,
                                          input logic [3:0] s);
      logic [1:0] rs;
      logic [1:0] cs;
      logic [1:0] rv;
      logic [1:0] cv;
      case (s)
         4'd0:  begin rs = 2'd1; cs = 2'd1; end
         4'd1:  begin rs = 2'd2; cs = 2'd2; end
         4'd2:  begin rs = 2'd1; cs = 2'd2; end
         4'd3:  begin rs = 2'd2; cs = 2'd1; end
         4'd4:  begin rs = 2'd0; cs = 2'd0; end
         4'd5:  begin rs = 2'd1; cs = 2'd0; end
         4'd6:  begin rs = 2'd2; cs = 2'd2; end
         4'd7:  begin rs = 2'd1; cs = 2'd2; end
         4'd8:  begin rs = 2'd2; cs = 2'd0; end
         4'd9:  begin rs = 2'd0; cs = 2'd1; end
         4'd10: begin rs = 2'd1; cs = 2'd0; end
         4'd11: begin rs = 2'd2; cs = 2'd1; end
         4'd12: begin rs = 2'd1; cs = 2'd1; end
         4'd13: begin rs = 2'd2; cs = 2'd0; end
         4'd14: begin rs = 2'd0; cs = 2'd2; end
         default: begin rs = 2'd0; cs = 2'd0; end
      endcase
      rv = (rs >= r) ? rs + 2'd1 : rs;
      cv = (cs >= c) ? cs + 2'd1 : cs;
      return {rv, cv};
   endfunction

endpackage
`default_nettype wire

// ----- sv/matrix4x4_inverse_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// matrix4x4_inverse_core: 4x4 fixed-point matrix inverse by adjugate
// Loads sixteen Q8.8 elements and returns the Q16.16 inverse with the
// Q32.32 determinant, saturating out-of-range values.
// ----------------------------------------------------------------------------
// Usage. Elements are sent row-major on req_elem_value; a request is taken at
// a rising edge where start is high and busy is low. The first fifteen
// requests are simply written into the matrix store and busy stays low.
// The sixteenth request raises busy until the whole inverse has been sent.
//
// The cofactor sequencer then reads the store one element at a time and runs
// each 3x3 minor through one shared multiplier, for all sixteen cofactors
// plus the determinant. Each cofactor goes to a second memory at its
// transposed position. A restoring divider then makes one quotient bit a
// cycle, dividing one inverse element at a time, each after the last.
//
// Results appear on the rsp_ ports for exactly one cycle, marked by
// rsp_valid, in row-major order with rsp_last_out on the sixteenth. The
// receiver cannot stall them. A zero determinant gives one result only, with
// rsp_singular and rsp_last_out set and all values zero.
// Synchronous reset returns the load count to zero and drops busy; the
// contents of both memories are left as they are and are always rewritten
// before they are read.
// ----------------------------------------------------------------------------
module matrix4x4_inverse_core import m4i_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [ELEM_WIDTH-1:0] req_elem_value,
   output logic                       rsp_valid,
   output logic      [31:0]           rsp_inv_value,
   output logic      [3:0]            rsp_inv_index,
   output logic      [63:0]           rsp_det_value,
   output logic                       rsp_singular,
   output logic                       rsp_saturated,
   output logic                       rsp_last_out
);

   localparam int CW  = 3 * ELEM_WIDTH + 3;
   localparam int DW  = 4 * ELEM_WIDTH + 5;
   localparam int SXW = (DW > 64) ? DW : 65;

   top_state_type state_ff, state_in;
   logic [3:0]    load_cnt_ff, load_cnt_in;
   logic [3:0]    k_ff, k_in;
   logic [63:0]   det_sat_ff, det_sat_in;
   logic          det_clip_ff, det_clip_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_inv_ff, rsp_inv_in;
   logic [3:0]    rsp_idx_ff, rsp_idx_in;
   logic [63:0]   rsp_det_ff, rsp_det_in;
   logic          rsp_sing_ff, rsp_sing_in;
   logic          rsp_sat_ff, rsp_sat_in;
   logic          rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  mat_we;
   logic [3:0]            mat_raddr;
   logic [ELEM_WIDTH-1:0] mat_rdata;
   logic                  cof_start;
   cof_wr_type            cof_wr;
   logic [CW-1:0]         cof_wdata;
   logic [CW-1:0]         cof_rdata;
   logic [DW-1:0]         det;
   logic                  cof_done;
   logic                  div_start;
   logic                  div_done;
   logic [31:0]           div_quo;
   logic                  div_clip;

   logic signed [SXW-1:0] det_x;
   logic                  det_clip;
   logic [63:0]           det_sat;

   assign busy   = (state_ff != TS_LOAD);
   assign accept = start && !busy;
   assign mat_we = accept;

   // Matrix store: written by requests, read by the cofactor sequencer.
   m4i_ram #(
      .WIDTH(ELEM_WIDTH),
      .DEPTH(MAT_DEPTH)
   ) u_mat_ram (
      .clock(clock),
      .we   (mat_we),
      .waddr(load_cnt_ff),
      .wdata(req_elem_value),
      .raddr(mat_raddr),
      .rdata(mat_rdata)
   );

   // Cofactor store, already transposed: entry k holds the adjugate element k.
   m4i_ram #(
      .WIDTH(CW),
      .DEPTH(MAT_DEPTH)
   ) u_cof_ram (
      .clock(clock),
      .we   (cof_wr.we),
      .waddr(cof_wr.addr),
      .wdata(cof_wdata),
      .raddr(k_ff),
      .rdata(cof_rdata)
   );

   m4i_cofactor #(
      .ELEM_WIDTH(ELEM_WIDTH)
   ) u_cofactor (
      .clock    (clock),
      .reset    (reset),
      .start    (cof_start),
      .mem_raddr(mat_raddr),
      .mem_rdata(mat_rdata),
      .cof_wr   (cof_wr),
      .cof_data (cof_wdata),
      .det      (det),
      .done     (cof_done)
   );

   m4i_divider #(
      .ELEM_WIDTH(ELEM_WIDTH)
   ) u_divider (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .cof  (cof_rdata),
      .det  (det),
      .done (div_done),
      .quo  (div_quo),
      .clip (div_clip)
   );

   // The determinant is reported in Q32.32, clipped to 64 bits.
   assign det_x    = SXW'($signed(det));
   assign det_clip = (det_x[SXW-1:63] != '0) && (det_x[SXW-1:63] != '1);
   assign det_sat  = det_clip ? (det_x[SXW-1] ? 64'h8000_0000_0000_0000
                                               : 64'h7fff_ffff_ffff_ffff)
                              : det_x[63:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= TS_LOAD;
         load_cnt_ff  <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_cnt_ff  <= load_cnt_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      det_sat_ff  <= det_sat_in;
      det_clip_ff <= det_clip_in;
      rsp_inv_ff  <= rsp_inv_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_det_ff  <= rsp_det_in;
      rsp_sing_ff <= rsp_sing_in;
      rsp_sat_ff  <= rsp_sat_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      load_cnt_in  = load_cnt_ff;
      k_in         = k_ff;
      det_sat_in   = det_sat_ff;
      det_clip_in  = det_clip_ff;
      rsp_valid_in = 1'b0;
      rsp_inv_in   = rsp_inv_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_det_in   = rsp_det_ff;
      rsp_sing_in  = rsp_sing_ff;
      rsp_sat_in   = rsp_sat_ff;
      rsp_last_in  = rsp_last_ff;
      cof_start    = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         TS_LOAD: begin
            if (accept) begin
               load_cnt_in = load_cnt_ff + 4'd1;
               if (load_cnt_ff == LAST_IDX) begin
                  cof_start = 1'b1;
                  state_in  = TS_COF;
               end
            end
         end
         TS_COF: begin
            if (cof_done) begin
               state_in = TS_CHECK;
            end
         end
         TS_CHECK: begin
            if (det == '0) begin
               rsp_valid_in = 1'b1;
               rsp_inv_in   = '0;
               rsp_idx_in   = '0;
               rsp_det_in   = '0;
               rsp_sing_in  = 1'b1;
               rsp_sat_in   = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = TS_LOAD;
            end else begin
               det_sat_in  = det_sat;
               det_clip_in = det_clip;
               k_in        = '0;
               state_in    = TS_RD;
            end
         end
         TS_RD: begin
            state_in = TS_DST;
         end
         TS_DST: begin
            div_start = 1'b1;
            state_in  = TS_DIV;
         end
         TS_DIV: begin
            if (div_done) begin
               rsp_valid_in = 1'b1;
               rsp_inv_in   = div_quo;
               rsp_idx_in   = k_ff;
               rsp_det_in   = det_sat_ff;
               rsp_sing_in  = 1'b0;
               rsp_sat_in   = div_clip | det_clip_ff;
               rsp_last_in  = (k_ff == LAST_IDX);
               if (k_ff == LAST_IDX) begin
                  state_in = TS_LOAD;
               end else begin
                  k_in     = k_ff + 4'd1;
                  state_in = TS_RD;
               end
            end
         end
         default: state_in = TS_LOAD;
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_inv_value = rsp_inv_ff;
   assign rsp_inv_index = rsp_idx_ff;
   assign rsp_det_value = rsp_det_ff;
   assign rsp_singular  = rsp_sing_ff;
   assign rsp_saturated = rsp_sat_ff;
   assign rsp_last_out  = rsp_last_ff;

endmodule
`default_nettype wire

// ----- sv/m4i_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// m4i_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module m4i_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule
`default_nettype wire

// ----- sv/m4i_cofactor.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// m4i_cofactor: cofactor and determinant sequencer
// Walks the 3x3 minor of every position through one shared multiplier,
// reading the matrix store one element at a time, and accumulates the
// determinant along the first row.
// ----------------------------------------------------------------------------
module m4i_cofactor import m4i_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic      [3:0]                mem_raddr,
   input  wire logic [ELEM_WIDTH-1:0]     mem_rdata,
   output cof_wr_type                     cof_wr,
   output logic      [3*ELEM_WIDTH+2:0]   cof_data,
   output logic      [4*ELEM_WIDTH+4:0]   det,
   output logic                           done
);

   localparam int TW = 2 * ELEM_WIDTH + 1;
   localparam int CW = 3 * ELEM_WIDTH + 3;
   localparam int PW = ELEM_WIDTH + CW;
   localparam int DW = 4 * ELEM_WIDTH + 5;

   cof_state_type           state_ff, state_in;
   logic [3:0]              q_ff, q_in;
   logic [3:0]              s_ff, s_in;
   logic [ELEM_WIDTH-1:0]   opa_ff, opa_in;
   logic signed [PW-1:0]    prod_ff, prod_in;
   logic signed [TW-1:0]    t_ff, t_in;
   logic signed [CW-1:0]    m_ff, m_in;
   logic signed [CW-1:0]    cof_ff, cof_in;
   logic signed [DW-1:0]    det_ff, det_in;

   op_kind_type             kind;
   logic [1:0]              r, c;
   logic signed [ELEM_WIDTH-1:0] elem_s;
   logic signed [CW-1:0]    bop;
   logic signed [PW-1:0]    prod_full;
   logic signed [CW-1:0]    cof_signed;

   assign kind   = op_kind(s_ff);
   assign r      = q_ff[3:2];
   assign c      = q_ff[1:0];
   assign elem_s = mem_rdata;

   always_comb begin
      if (state_ff == CS_DEXEC) begin
         bop = cof_ff;
      end else if (kind == OP_MSET || kind == OP_MSUB) begin
         bop = CW'($signed(opa_ff));
      end else begin
         bop = CW'(t_ff);
      end
      prod_full  = elem_s * bop;
      cof_signed = (r[0] ^ c[0]) ? -m_ff : m_ff;
   end

   assign cof_data = cof_signed;
   assign det      = det_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         q_ff     <= '0;
         s_ff     <= '0;
      end else begin
         state_ff <= state_in;
         q_ff     <= q_in;
         s_ff     <= s_in;
      end
      opa_ff  <= opa_in;
      prod_ff <= prod_in;
      t_ff    <= t_in;
      m_ff    <= m_in;
      cof_ff  <= cof_in;
      det_ff  <= det_in;
   end

   always_comb begin
      state_in    = state_ff;
      q_in        = q_ff;
      s_in        = s_ff;
      opa_in      = opa_ff;
      prod_in     = prod_ff;
      t_in        = t_ff;
      m_in        = m_ff;
      cof_in      = cof_ff;
      det_in      = det_ff;
      mem_raddr   = '0;
      cof_wr.we   = 1'b0;
      cof_wr.addr = {c, r};
      done        = 1'b0;
      case (state_ff)
         CS_IDLE: begin
            if (start) begin
               det_in   = '0;
               q_in     = '0;
               s_in     = '0;
               state_in = CS_ISSUE;
            end
         end
         CS_ISSUE: begin
            mem_raddr = op_addr(r, c, s_ff);
            state_in  = CS_EXEC;
         end
         CS_EXEC: begin
            if (kind == OP_LDA) begin
               opa_in   = mem_rdata;
               s_in     = s_ff + 4'd1;
               state_in = CS_ISSUE;
            end else begin
               prod_in  = prod_full;
               state_in = CS_ACC;
            end
         end
         CS_ACC: begin
            case (kind)
               OP_MSET:  t_in = prod_ff[TW-1:0];
               OP_MSUB:  t_in = t_ff - prod_ff[TW-1:0];
               OP_MMSET: m_in = prod_ff[CW-1:0];
               OP_MMSUB: m_in = m_ff - prod_ff[CW-1:0];
               OP_MMADD: m_in = m_ff + prod_ff[CW-1:0];
               default:  t_in = t_ff;
            endcase
            if (s_ff == LAST_OP) begin
               state_in = CS_WRITE;
            end else begin
               s_in     = s_ff + 4'd1;
               state_in = CS_ISSUE;
            end
         end
         CS_WRITE: begin
            cof_wr.we = 1'b1;
            cof_in    = cof_signed;
            if (r == 2'd0) begin
               state_in = CS_DISSUE;
            end else if (q_ff == LAST_IDX) begin
               done     = 1'b1;
               state_in = CS_IDLE;
            end else begin
               q_in     = q_ff + 4'd1;
               s_in     = '0;
               state_in = CS_ISSUE;
            end
         end
         CS_DISSUE: begin
            mem_raddr = {2'b00, c};
            state_in  = CS_DEXEC;
         end
         CS_DEXEC: begin
            prod_in  = prod_full;
            state_in = CS_DACC;
         end
         CS_DACC: begin
            det_in   = det_ff + DW'(prod_ff);
            q_in     = q_ff + 4'd1;
            s_in     = '0;
            state_in = CS_ISSUE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/m4i_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// m4i_divider: signed restoring divider with Q16.16 saturation
// Divides a cofactor shifted up by the fraction alignment by the determinant,
// one quotient bit a cycle, rounding toward zero.
// ----------------------------------------------------------------------------
module m4i_divider import m4i_pkg::*; #(
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [3*ELEM_WIDTH+2:0] cof,
   input  wire logic [4*ELEM_WIDTH+4:0] det,
   output logic                         done,
   output logic      [31:0]             quo,
   output logic                         clip
);

   localparam int CW  = 3 * ELEM_WIDTH + 3;
   localparam int DW  = 4 * ELEM_WIDTH + 5;
   localparam int NW  = CW + INV_SHIFT;
   localparam int DXW = DW + 32;
   localparam int WW  = ((NW > DXW) ? NW : DXW) + 1;

   div_state_type  state_ff, state_in;
   logic [5:0]     cnt_ff, cnt_in;
   logic [WW-1:0]  rem_ff, rem_in;
   logic [WW-1:0]  dsh_ff, dsh_in;
   logic [32:0]    q_ff, q_in;
   logic           neg_ff, neg_in;

   logic [CW-1:0]  num_mag;
   logic [DW-1:0]  den_mag;
   logic           ge;
   logic [32:0]    qs;

   assign num_mag = cof[CW-1] ? -cof : cof;
   assign den_mag = det[DW-1] ? -det : det;
   assign ge      = rem_ff >= dsh_ff;

   // Quotient bit 32 set means the magnitude is out of range whatever follows.
   assign qs   = neg_ff ? -{1'b0, q_ff[31:0]} : {1'b0, q_ff[31:0]};
   assign clip = q_ff[32] | (qs[32] != qs[31]);
   assign quo  = clip ? (neg_ff ? 32'h8000_0000 : 32'h7fff_ffff) : qs[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      q_ff   <= q_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      dsh_in   = dsh_ff;
      q_in     = q_ff;
      neg_in   = neg_ff;
      done     = 1'b0;
      case (state_ff)
         DV_IDLE: begin
            if (start) begin
               rem_in   = WW'(num_mag) << INV_SHIFT;
               dsh_in   = WW'(den_mag) << 32;
               neg_in   = cof[CW-1] ^ det[DW-1];
               q_in     = '0;
               cnt_in   = '0;
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            rem_in = ge ? rem_ff - dsh_ff : rem_ff;
            q_in   = {q_ff[31:0], ge};
            dsh_in = dsh_ff >> 1;
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd32) begin
               state_in = DV_FIN;
            end
         end
         DV_FIN: begin
            done     = 1'b1;
            state_in = DV_IDLE;
         end
         default: state_in = DV_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ----- sv/m4i_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// m4i_checker: port-level checks for the inverse core
// Watches the result channel and busy over time.
// ----------------------------------------------------------------------------
module m4i_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [31:0] rsp_inv_value,
   input wire logic [3:0]  rsp_inv_index,
   input wire logic        rsp_singular,
   input wire logic        rsp_last_out
);

   // A singular matrix gives a single, empty, final result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |->
         rsp_last_out && rsp_inv_value == 32'd0 && rsp_inv_index == 4'd0)
      else $error("singular result malformed");

   // The final result of a regular matrix is its last element.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_out && !rsp_singular |-> rsp_inv_index == 4'd15)
      else $error("last result at wrong index");

   // Results are spaced by the divider, never in adjacent cycles.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("results in adjacent cycles");

   // Busy only rises after a request was taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("busy rose without a request");

   // Until the final result, the block stays busy.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_out |-> busy)
      else $error("idle before final result");

endmodule

bind matrix4x4_inverse_core m4i_checker u_m4i_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_valid    (rsp_valid),
   .rsp_inv_value(rsp_inv_value),
   .rsp_inv_index(rsp_inv_index),
   .rsp_singular (rsp_singular),
   .rsp_last_out (rsp_last_out)
);
`default_nettype wire
